/* sv/assert_macros.svh */
// Assertion helpers for the checker file dcte_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/dcte_pkg.sv */
package dcte_pkg;

    localparam int unsigned NUM_CHECK_BITS = 8;

    // Parity masks for the 64-bit doubleword check bits
    localparam logic [63:0] ECC_MASKS [NUM_CHECK_BITS] = '{
        64'h0738C808099264FF,
        64'h38C808099264FF07,
        64'hC808099264FF0738,
        64'h08099264FF0738C8,
        64'h099264FF0738C808,
        64'h9264FF0738C80809,
        64'h64FF0738C8080992,
        64'hFF0738C808099264
    };

    // Valid line state codes
    localparam logic [4:0] LSTATE_A = 5'h0F;
    localparam logic [4:0] LSTATE_B = 5'h13;
    localparam logic [4:0] LSTATE_C = 5'h19;
    localparam logic [4:0] LSTATE_D = 5'h16;
    localparam logic [4:0] LSTATE_E = 5'h1C;

    localparam logic CMD_TAG  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] tag_high;
        logic [39:0] tag_low;
        logic [63:0] data_word;
        logic [7:0]  check_byte;
        logic        last;
    } req_t;

    typedef struct packed {
        logic       state_err;
        logic       addr_err;
        logic [4:0] line_state;
    } tag_res_t;

    typedef struct packed {
        logic       single_err;
        logic       multi_err;
        logic [7:0] syndrome;
    } data_res_t;

    typedef struct packed {
        logic       tag_state_error;
        logic       tag_address_error;
        logic       data_single_error;
        logic       data_multi_error;
        logic [7:0] syndrome;
        logic [4:0] line_state;
        logic [3:0] summary_flags;
        logic       last_out;
    } rsp_t;

endpackage

/* sv/dcte_req_if.sv */
interface dcte_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] tag_high;
    logic [39:0] tag_low;
    logic [63:0] data_word;
    logic [7:0]  check_byte;
    logic        last;

    modport source (
        output valid, cmd, tag_high, tag_low, data_word, check_byte, last,
        input  ready
    );
    modport sink (
        input  valid, cmd, tag_high, tag_low, data_word, check_byte, last,
        output ready
    );
endinterface

/* sv/dcte_rsp_if.sv */
interface dcte_rsp_if;
    logic       valid;
    logic       ready;
    logic       tag_state_error;
    logic       tag_address_error;
    logic       data_single_error;
    logic       data_multi_error;
    logic [7:0] syndrome;
    logic [4:0] line_state;
    logic [3:0] summary_flags;
    logic       last_out;

    modport source (
        output valid, tag_state_error, tag_address_error, data_single_error,
               data_multi_error, syndrome, line_state, summary_flags, last_out,
        input  ready
    );
    modport sink (
        input  valid, tag_state_error, tag_address_error, data_single_error,
               data_multi_error, syndrome, line_state, summary_flags, last_out,
        output ready
    );
endinterface

/* sv/dcache_tag_ecc_checker.sv */
// An accepted request is held in the input register, and its checked result is
// then registered in the result register, from which it can be taken.
// Throughput: one request per cycle with no result stalls; a held result
// blocks the input only once the input register also holds a request.
// Reset (rst_n low, async): both stages empty, sticky error summary cleared.
module dcache_tag_ecc_checker (
    input  logic        clk,
    input  logic        rst_n,
    dcte_req_if.sink    req_ch,
    dcte_rsp_if.source  rsp_ch
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    dcte_pkg::req_t     s1_req_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    dcte_pkg::rsp_t     rsp_reg;
    dcte_pkg::rsp_t     rsp_next;
    logic [3:0]         sticky_reg;
    logic [3:0]         sticky_next;

    logic               s1_adv;
    logic               req_acc;
    logic [3:0]         flags;
    dcte_pkg::tag_res_t  tag_res;
    dcte_pkg::data_res_t data_res;

    dcte_tag_check u_tag (
        .enable   (s1_req_reg.cmd == dcte_pkg::CMD_TAG),
        .tag_high (s1_req_reg.tag_high),
        .tag_low  (s1_req_reg.tag_low),
        .res      (tag_res)
    );

    dcte_data_check u_data (
        .enable     (s1_req_reg.cmd == dcte_pkg::CMD_DATA),
        .data_word  (s1_req_reg.data_word),
        .check_byte (s1_req_reg.check_byte),
        .res        (data_res)
    );

    assign s1_adv       = s1_valid_reg && (!out_valid_reg || rsp_ch.ready);
    assign req_ch.ready = !s1_valid_reg || s1_adv;
    assign req_acc      = req_ch.valid && req_ch.ready;

    always_comb
    begin
        flags = sticky_reg | {data_res.multi_err, data_res.single_err,
                              tag_res.addr_err, tag_res.state_err};

        rsp_next.tag_state_error   = tag_res.state_err;
        rsp_next.tag_address_error = tag_res.addr_err;
        rsp_next.data_single_error = data_res.single_err;
        rsp_next.data_multi_error  = data_res.multi_err;
        rsp_next.syndrome          = data_res.syndrome;
        rsp_next.line_state        = tag_res.line_state;
        rsp_next.summary_flags     = flags;
        rsp_next.last_out          = s1_req_reg.last;

        s1_valid_next  = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_reg);

        sticky_next = sticky_reg;
        if (s1_adv)
        begin
            sticky_next = s1_req_reg.last ? 4'd0 : flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sticky_reg    <= 4'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            sticky_reg    <= sticky_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_req_reg.cmd        <= req_ch.cmd;
            s1_req_reg.tag_high   <= req_ch.tag_high;
            s1_req_reg.tag_low    <= req_ch.tag_low;
            s1_req_reg.data_word  <= req_ch.data_word;
            s1_req_reg.check_byte <= req_ch.check_byte;
            s1_req_reg.last       <= req_ch.last;
        end
        if (s1_adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_ch.valid             = out_valid_reg;
    assign rsp_ch.tag_state_error   = rsp_reg.tag_state_error;
    assign rsp_ch.tag_address_error = rsp_reg.tag_address_error;
    assign rsp_ch.data_single_error = rsp_reg.data_single_error;
    assign rsp_ch.data_multi_error  = rsp_reg.data_multi_error;
    assign rsp_ch.syndrome          = rsp_reg.syndrome;
    assign rsp_ch.line_state        = rsp_reg.line_state;
    assign rsp_ch.summary_flags     = rsp_reg.summary_flags;
    assign rsp_ch.last_out          = rsp_reg.last_out;

endmodule

/* sv/dcte_tag_check.sv */
module dcte_tag_check (
    input  logic                enable,
    input  logic [31:0]         tag_high,
    input  logic [39:0]         tag_low,
    output dcte_pkg::tag_res_t  res
);

    logic [4:0] lstate;
    logic       state_ok;
    logic       par_hi;
    logic       par_lo;

    always_comb
    begin
        lstate   = tag_high[29:25];
        state_ok = (lstate == dcte_pkg::LSTATE_A) || (lstate == dcte_pkg::LSTATE_B) ||
                   (lstate == dcte_pkg::LSTATE_C) || (lstate == dcte_pkg::LSTATE_D) ||
                   (lstate == dcte_pkg::LSTATE_E);
        par_hi   = ^tag_low[39:26];
        par_lo   = ^tag_low[25:13];

        res.line_state = enable ? lstate : 5'd0;
        res.state_err  = enable && !state_ok;
        // parity only meaningful on a valid line
        res.addr_err   = enable && state_ok &&
                         ((tag_low[11] ^ par_hi) || (tag_low[10] ^ par_lo));
    end

endmodule

/* sv/dcte_data_check.sv */
module dcte_data_check (
    input  logic                enable,
    input  logic [63:0]         data_word,
    input  logic [7:0]          check_byte,
    output dcte_pkg::data_res_t res
);

    logic [7:0] ecc;
    logic [7:0] syn;
    logic       nonzero;
    logic       one_hot;

    always_comb
    begin
        for (int i = 0; i < dcte_pkg::NUM_CHECK_BITS; i++)
        begin
            ecc[i] = ^(data_word & dcte_pkg::ECC_MASKS[i]);
        end
        syn     = enable ? (ecc ^ check_byte) : 8'd0;
        nonzero = (syn != 8'd0);
        one_hot = nonzero && ((syn & (syn - 8'd1)) == 8'd0);

        res.syndrome   = syn;
        res.single_err = one_hot;
        res.multi_err  = nonzero && !one_hot;
    end

endmodule

/* sv/dcte_checker.sv */
`include "assert_macros.svh"

module dcte_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       tag_state_error,
    input logic       tag_address_error,
    input logic       data_single_error,
    input logic       data_multi_error,
    input logic [7:0] syndrome,
    input logic [4:0] line_state,
    input logic [3:0] summary_flags
);

    logic [3:0]  errs;
    logic [20:0] payload;
    logic        stalled;
    logic        in_summary;
    logic        tag_err;
    logic        data_err;
    logic        single_ok;

    assign errs = {data_multi_error, data_single_error, tag_address_error, tag_state_error};
    assign payload    = {errs, syndrome, line_state, summary_flags};
    assign stalled    = rsp_valid && !rsp_ready;
    assign in_summary = ((summary_flags & errs) == errs);
    assign tag_err    = tag_state_error || tag_address_error;
    assign data_err   = data_single_error || data_multi_error;
    assign single_ok  = (($countones(syndrome) == 1) == data_single_error);

    // stalled response keeps its payload
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, stalled, rsp_valid && $stable(payload))

    // at most one error class per response, and all of it in the summary
    `ASSERT_IMPL(a_err_onehot, clk, rst_n, rsp_valid, $onehot0(errs) && in_summary)

    // tag errors never carry a data syndrome
    `ASSERT_IMPL(a_tag_no_syn, clk, rst_n, rsp_valid && tag_err, syndrome == 8'd0)

    // single error means exactly one syndrome bit; data errors show no line state
    `ASSERT_IMPL(a_single_syn, clk, rst_n, rsp_valid && data_err, single_ok && line_state == 5'd0)

endmodule

bind dcache_tag_ecc_checker dcte_checker u_dcte_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp_ch.valid),
    .rsp_ready         (rsp_ch.ready),
    .tag_state_error   (rsp_ch.tag_state_error),
    .tag_address_error (rsp_ch.tag_address_error),
    .data_single_error (rsp_ch.data_single_error),
    .data_multi_error  (rsp_ch.data_multi_error),
    .syndrome          (rsp_ch.syndrome),
    .line_state        (rsp_ch.line_state),
    .summary_flags     (rsp_ch.summary_flags)
);

/* bench/dcte_result_checker.sv */
module dcte_result_checker
    import dcte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dcte_req_if  req_ch,
    dcte_rsp_if  rsp_ch,
    output int   failures,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    rsp_t       expected_q[$];
    logic [3:0] error_summary;
    int         fail_total;

    // Sticky summary is updated here, so call once per accepted request, in order.
    function automatic rsp_t predict_entry_check(input req_t r);
        rsp_t       e;
        logic [4:0] st;
        logic [7:0] ecc;
        e = '0;
        if (r.cmd == CMD_TAG) begin
            st = r.tag_high[29:25];
            e.line_state = st;
            if (st inside {LSTATE_A, LSTATE_B, LSTATE_C, LSTATE_D, LSTATE_E})
                e.tag_address_error = (r.tag_low[11] != ^r.tag_low[39:26]) ||
                                      (r.tag_low[10] != ^r.tag_low[25:13]);
            else
                e.tag_state_error = 1'b1;
        end else begin
            for (int i = 0; i < NUM_CHECK_BITS; i++)
                ecc[i] = ^(r.data_word & ECC_MASKS[i]);
            e.syndrome = ecc ^ r.check_byte;
            e.data_single_error = ($countones(e.syndrome) == 1);
            e.data_multi_error  = ($countones(e.syndrome) > 1);
        end
        error_summary = error_summary | {e.data_multi_error, e.data_single_error,
                                         e.tag_address_error, e.tag_state_error};
        e.summary_flags = error_summary;
        e.last_out = r.last;
        if (r.last)
            error_summary = '0;
        return e;
    endfunction

    function automatic string describe(input rsp_t x);
        return $sformatf("st=%0b ad=%0b se=%0b me=%0b syn=%02h ls=%02h sum=%h last=%0b",
                         x.tag_state_error, x.tag_address_error, x.data_single_error,
                         x.data_multi_error, x.syndrome, x.line_state, x.summary_flags,
                         x.last_out);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        req_t r;
        rsp_t seen;
        rsp_t want;
        if (!rst_n) begin
            expected_q.delete();
            error_summary = '0;
            fail_total = 0;
            failures <= 0;
            outstanding <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen.tag_state_error   = rsp_ch.tag_state_error;
                seen.tag_address_error = rsp_ch.tag_address_error;
                seen.data_single_error = rsp_ch.data_single_error;
                seen.data_multi_error  = rsp_ch.data_multi_error;
                seen.syndrome          = rsp_ch.syndrome;
                seen.line_state        = rsp_ch.line_state;
                seen.summary_flags     = rsp_ch.summary_flags;
                seen.last_out          = rsp_ch.last_out;
                if (expected_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("%0t: result with no request outstanding: %s",
                                 $time, describe(seen));
                end else begin
                    want = expected_q.pop_front();
                    if (seen.tag_state_error   !== want.tag_state_error   ||
                        seen.tag_address_error !== want.tag_address_error ||
                        seen.data_single_error !== want.data_single_error ||
                        seen.data_multi_error  !== want.data_multi_error  ||
                        seen.syndrome          !== want.syndrome          ||
                        seen.line_state        !== want.line_state        ||
                        seen.summary_flags     !== want.summary_flags     ||
                        seen.last_out          !== want.last_out) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("%0t: result mismatch", $time);
                            $display("    expected %s", describe(want));
                            $display("    actual   %s", describe(seen));
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                r.cmd        = req_ch.cmd;
                r.tag_high   = req_ch.tag_high;
                r.tag_low    = req_ch.tag_low;
                r.data_word  = req_ch.data_word;
                r.check_byte = req_ch.check_byte;
                r.last       = req_ch.last;
                expected_q.push_back(predict_entry_check(r));
            end
            failures <= fail_total;
            outstanding <= expected_q.size();
        end
    end

endmodule

/* bench/dcache_tag_ecc_checker_tb.sv */
module dcache_tag_ecc_checker_tb;
    import dcte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES     = 48;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int NUM_PHASES      = 4;

    localparam int unsigned SEND_IDLE_PCT [NUM_PHASES] = '{0, 71, 0, 15};
    localparam int unsigned RCV_STALL_PCT [NUM_PHASES] = '{0, 0, 71, 15};
    localparam logic [4:0]  VALID_STATES  [5] =
        '{LSTATE_A, LSTATE_B, LSTATE_C, LSTATE_D, LSTATE_E};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        rsp_ready = 1'b0;
    int unsigned send_idle_pct;
    int unsigned rcv_stall_pct = 0;
    int          hold_requests = 0;
    int          holds_taken = 0;
    int          hold_left = 0;
    int          failures;
    int          outstanding;

    dcte_req_if req_ch();
    dcte_rsp_if rsp_ch();

    assign rsp_ch.ready = rsp_ready;

    dcache_tag_ecc_checker i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch),
        .rsp_ch (rsp_ch)
    );

    dcte_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_ch      (req_ch),
        .rsp_ch      (rsp_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    // Receiver: long hold-off on demand, otherwise random stalls.
    always @(posedge clk) begin
        if (holds_taken != hold_requests) begin
            holds_taken <= hold_requests;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    function automatic logic [7:0] check_bits_of(input logic [63:0] dw);
        logic [7:0] ecc;
        for (int i = 0; i < NUM_CHECK_BITS; i++)
            ecc[i] = ^(dw & ECC_MASKS[i]);
        return ecc;
    endfunction

    // flip[1] breaks the upper tag parity, flip[0] the lower one.
    function automatic req_t tag_request(input logic [4:0] state, input logic [1:0] flip,
                                         input logic last);
        req_t        r;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        r.cmd = CMD_TAG;
        r.tag_high = $urandom;
        r.tag_high[29:25] = state;
        r.tag_low = rnd[39:0];
        r.tag_low[11] = ^r.tag_low[39:26] ^ flip[1];
        r.tag_low[10] = ^r.tag_low[25:13] ^ flip[0];
        r.data_word = {$urandom, $urandom};
        r.check_byte = 8'($urandom_range(255));
        r.last = last;
        return r;
    endfunction

    function automatic req_t data_request(input logic [63:0] dw, input logic [7:0] flip,
                                          input logic last);
        req_t        r;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        r.cmd = CMD_DATA;
        r.tag_high = $urandom;
        r.tag_low = rnd[39:0];
        r.data_word = dw;
        r.check_byte = check_bits_of(dw) ^ flip;
        r.last = last;
        return r;
    endfunction

    function automatic req_t random_request();
        req_t        r;
        logic        last;
        logic [4:0]  st;
        logic [1:0]  flip;
        int unsigned kind;
        last = ($urandom_range(4) == 0);
        if ($urandom_range(1) == 0) begin
            st = ($urandom_range(9) < 7) ? VALID_STATES[$urandom_range(4)]
                                         : 5'($urandom_range(31));
            flip = ($urandom_range(3) == 0) ? 2'($urandom_range(3, 1)) : 2'b00;
            r = tag_request(st, flip, last);
        end else begin
            kind = $urandom_range(9);
            if (kind < 4)
                r = data_request({$urandom, $urandom}, 8'h00, last);
            else if (kind < 6)
                r = data_request({$urandom, $urandom}, 8'h01 << $urandom_range(7), last);
            else if (kind < 7) begin
                r = data_request({$urandom, $urandom}, 8'h00, last);
                r.data_word[$urandom_range(63)] ^= 1'b1;
            end else
                r = data_request({$urandom, $urandom}, 8'($urandom_range(255)), last);
        end
        return r;
    endfunction

    // Returns right after the edge at which the request was taken; valid stays up.
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= r.cmd;
        req_ch.tag_high <= r.tag_high;
        req_ch.tag_low <= r.tag_low;
        req_ch.data_word <= r.data_word;
        req_ch.check_byte <= r.check_byte;
        req_ch.last <= r.last;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    initial begin
        req_t r;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_TAG;
        req_ch.tag_high = '0;
        req_ch.tag_low = '0;
        req_ch.data_word = '0;
        req_ch.check_byte = '0;
        req_ch.last = 1'b0;
        send_idle_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // all-zero tag: invalid state, parity ignored
        r = '0;
        send_request(r);
        // all-ones tag: invalid state 0x1f
        r = '1;
        r.cmd = CMD_TAG;
        send_request(r);
        foreach (VALID_STATES[i])
            send_request(tag_request(VALID_STATES[i], 2'b00, i == 4));
        send_request(tag_request(LSTATE_A, 2'b10, 1'b0));
        send_request(tag_request(LSTATE_D, 2'b01, 1'b0));
        send_request(tag_request(LSTATE_E, 2'b11, 1'b1));
        send_request(tag_request(5'h00, 2'b11, 1'b0));
        // zero word, clean check byte
        send_request(data_request(64'h0, 8'h00, 1'b0));
        send_request(data_request('1, 8'h00, 1'b0));
        send_request(data_request({$urandom, $urandom}, 8'h08, 1'b0));
        send_request(data_request(64'h0, 8'hFF, 1'b1));
        // everything high: data request with check byte 0xff
        r = '1;
        send_request(r);
        r = data_request({$urandom, $urandom}, 8'h00, 1'b1);
        r.data_word[0] = ~r.data_word[0];
        send_request(r);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = SEND_IDLE_PCT[ph];
            rcv_stall_pct <= RCV_STALL_PCT[ph];
            // back up the pipeline while the sender keeps pushing
            if (ph == 0 || ph == 3)
                hold_requests <= hold_requests + 1;
            repeat (ITEMS_PER_PHASE)
                send_request(random_request());
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("dcache_tag_ecc_checker verification clean");
        else
            $display("dcache_tag_ecc_checker verification failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("dcache_tag_ecc_checker verification failed");
        $finish;
    end

endmodule
